// ===== src/ptgp_pkg.sv =====
// ---------------------------------------------------------------------------
// ptgp_pkg: shared constants and types for pixel_to_ground_point
// Field widths, coefficient slots, datapath widths and the sideband record
// that travels with an item through the divider.
// ---------------------------------------------------------------------------
package ptgp_pkg;

   localparam int COEF_WIDTH  = 32;
   localparam int PIXEL_WIDTH = 16;
   localparam int POINT_WIDTH = 32;

   localparam int NUM_COEFS  = 21;
   localparam int IDX_WIDTH  = 5;
   localparam int KINV_BASE  = 0;
   localparam int ROT_BASE   = 9;
   localparam int TRANS_BASE = 18;
   localparam int TZ_SLOT    = 20;

   // fraction bits of the pixel format; 1.0 is 1 << PIX_FRAC
   localparam int PIX_FRAC = 4;

   // first matrix product
   localparam int KP_W   = COEF_WIDTH + PIXEL_WIDTH + 1;
   localparam int C_W    = KP_W + 2;
   localparam int CMAG_W = C_W - 1;
   localparam int CLO_W  = (CMAG_W + 1) / 2;
   localparam int CHI_W  = CMAG_W - CLO_W;
   localparam int RC_W   = COEF_WIDTH + CMAG_W;

   // 63-bit saturating magnitude, 64 bits with its sign
   localparam int SAT_W = 63;

   // rotation product and ray direction
   localparam int W_SHIFT = 24;
   localparam int TERM_W  = 64 - W_SHIFT;
   localparam int W_W     = TERM_W + 2;
   localparam int WMAG_W  = W_W - 1;

   // scale division
   localparam int NUM_SHIFT = 28;
   localparam int NUM_W     = COEF_WIDTH + NUM_SHIFT;
   localparam int DIV_STEPS = NUM_W;

   // scale times direction
   localparam int SLO_W = NUM_W / 2;
   localparam int SHI_W = NUM_W - SLO_W;
   localparam int WLO_W = (WMAG_W + 1) / 2;
   localparam int WHI_W = WMAG_W - WLO_W;
   localparam int PA_W  = SLO_W + WMAG_W;
   localparam int PB_W  = SHI_W + WMAG_W;
   localparam int PS_W  = NUM_W + WMAG_W;

   // final point
   localparam int P_SHIFT     = 36;
   localparam int FS_W        = 64 - P_SHIFT;
   localparam int TRANS_SHIFT = 8;
   localparam int TSH_W       = COEF_WIDTH - TRANS_SHIFT;
   localparam int SUM_W       = ((FS_W > TSH_W) ? FS_W : TSH_W) + 1;

   localparam logic signed [63:0] PT_MAX = (64'sd1 <<< (POINT_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] PT_MIN = -PT_MAX - 64'sd1;

   typedef enum logic {
      KIND_LOAD    = 1'b0,
      KIND_PROJECT = 1'b1
   } ptgp_kind_type;

   typedef struct packed {
      logic                         invalid;
      logic [2:0]                   wneg;
      logic [2:0][WMAG_W-1:0]       wmag;
      logic [2:0][TSH_W-1:0]        tsh;
   } ptgp_side_type;

endpackage

// ===== src/ptgp_div.sv =====
// ---------------------------------------------------------------------------
// ptgp_div: pipelined restoring divider
// One quotient bit per stage, sideband record carried alongside.
// ---------------------------------------------------------------------------
module ptgp_div
   import ptgp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NUM_W-1:0]    in_num,
   input  logic [WMAG_W-1:0]   in_dvs,
   input  ptgp_side_type       in_side,
   output logic                out_valid,
   output logic [NUM_W-1:0]    out_quot,
   output ptgp_side_type       out_side
);

   logic                vld_ff  [DIV_STEPS];
   logic [WMAG_W-1:0]   rem_ff  [DIV_STEPS];
   logic [NUM_W-1:0]    num_ff  [DIV_STEPS];
   logic [NUM_W-1:0]    quot_ff [DIV_STEPS];
   logic [WMAG_W-1:0]   dvs_ff  [DIV_STEPS];
   ptgp_side_type       side_ff [DIV_STEPS];

   logic                vld_in  [DIV_STEPS];
   logic [WMAG_W-1:0]   rem_in  [DIV_STEPS];
   logic [NUM_W-1:0]    num_in  [DIV_STEPS];
   logic [NUM_W-1:0]    quot_in [DIV_STEPS];
   logic [WMAG_W-1:0]   dvs_in  [DIV_STEPS];
   ptgp_side_type       side_in [DIV_STEPS];

   always_comb begin
      logic              v;
      logic [WMAG_W-1:0] r;
      logic [NUM_W-1:0]  n;
      logic [NUM_W-1:0]  q;
      logic [WMAG_W-1:0] d;
      ptgp_side_type     s;
      logic [WMAG_W:0]   trial;
      logic [WMAG_W:0]   diff;
      logic              fits;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (k == 0) begin
            v = in_valid;
            r = '0;
            n = in_num;
            q = '0;
            d = in_dvs;
            s = in_side;
         end else begin
            v = vld_ff[k-1];
            r = rem_ff[k-1];
            n = num_ff[k-1];
            q = quot_ff[k-1];
            d = dvs_ff[k-1];
            s = side_ff[k-1];
         end
         trial      = {r, n[NUM_W-1]};
         diff       = trial - {1'b0, d};
         fits       = (trial >= {1'b0, d});
         vld_in[k]  = v;
         rem_in[k]  = fits ? diff[WMAG_W-1:0] : trial[WMAG_W-1:0];
         num_in[k]  = {n[NUM_W-2:0], 1'b0};
         quot_in[k] = {q[NUM_W-2:0], fits};
         dvs_in[k]  = d;
         side_in[k] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
      side_ff <= side_in;
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_quot  = quot_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

`ifndef SYNTHESIS
   // remainder must stay below a nonzero divisor
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && (dvs_ff[0] != '0)) |-> (rem_ff[0] < dvs_ff[0]))
      else $error("divider remainder not reduced");
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DIV_STEPS-1] && (dvs_ff[DIV_STEPS-1] != '0))
         |-> (rem_ff[DIV_STEPS-1] < dvs_ff[DIV_STEPS-1]))
      else $error("divider final remainder not reduced");
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && (in_dvs == '0)) |-> in_side.invalid)
      else $error("zero divisor on a valid item");
`endif

endmodule

// ===== src/pixel_to_ground_point.sv =====
// ---------------------------------------------------------------------------
// pixel_to_ground_point: pixel to vehicle ground-plane point
// Coefficient store for Kinv, R and t; fully pipelined projection
// c = Kinv*[x,y,1], w = R*c, scale = -tz/w.z, point = scale*w + t.
// ---------------------------------------------------------------------------
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ------------------------------
//  request   req_kind req_coef_index             transfer when start && !busy
//            req_coef_value req_pixel_x/y
//  response  rsp_point_x/y/z rsp_valid_res       one-cycle strobe rsp_valid
//
//  one item per clock while busy is low; a project item passes 72 register
//  stages: 7 stages of matrix math, a 60-stage divider (one quotient bit
//  per stage) and 5 stages of scaling and translation, and its strobe
//  rsp_valid is driven from the last of those registers
//  a load item updates the store at its transfer and gives no result;
//  items already in flight keep the coefficients they picked up
//  synchronous reset clears the store to zero and empties the pipeline;
//  busy is high only while reset is held
//  the receiver cannot stall, so nothing in the pipeline ever waits
//
module pixel_to_ground_point
   import ptgp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [IDX_WIDTH-1:0]          req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_value,
   input  logic [PIXEL_WIDTH-1:0]        req_pixel_x,
   input  logic [PIXEL_WIDTH-1:0]        req_pixel_y,
   output logic                          rsp_valid,
   output logic signed [POINT_WIDTH-1:0] rsp_point_x,
   output logic signed [POINT_WIDTH-1:0] rsp_point_y,
   output logic signed [POINT_WIDTH-1:0] rsp_point_z,
   output logic                          rsp_valid_res
);

   // request side
   logic acc;
   logic load_wr;
   logic proj;

   assign busy    = reset;
   assign acc     = start && !busy;
   assign load_wr = acc && (req_kind == KIND_LOAD)
                    && (req_coef_index < IDX_WIDTH'(NUM_COEFS));
   assign proj    = acc && (req_kind == KIND_PROJECT);

   // coefficient store, all fixed-place reads
   logic signed [COEF_WIDTH-1:0] coef_ff [NUM_COEFS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COEFS; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (load_wr) begin
         coef_ff[req_coef_index] <= req_coef_value;
      end
   end

   // valid bits of the front stages
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   // stage 1: Kinv column products, snapshot of R, tz, t
   logic signed [KP_W-1:0]       kx_in [3], kx_ff [3];
   logic signed [KP_W-1:0]       ky_in [3], ky_ff [3];
   logic signed [COEF_WIDTH-1:0] kc_ff [3];
   logic signed [COEF_WIDTH-1:0] r1_ff [9];
   logic signed [COEF_WIDTH-1:0] tz1_ff;
   logic [2:0][TSH_W-1:0]        tsh_in, tsh1_ff;

   always_comb begin
      logic signed [COEF_WIDTH-1:0] tv;
      for (int i = 0; i < 3; i++) begin
         kx_in[i]  = coef_ff[KINV_BASE+3*i]   * $signed({1'b0, req_pixel_x});
         ky_in[i]  = coef_ff[KINV_BASE+3*i+1] * $signed({1'b0, req_pixel_y});
         tv        = coef_ff[TRANS_BASE+i] >>> TRANS_SHIFT;
         tsh_in[i] = tv[TSH_W-1:0];
      end
   end

   // stage 2: c and its magnitude, |R|
   logic signed [C_W-1:0]     c_in [3];
   logic [CMAG_W-1:0]         cmag_ff [3];
   logic [2:0]                cneg_ff;
   logic [COEF_WIDTH-1:0]     rmag_in [9], rmag_ff [9];
   logic [8:0]                rneg_ff;
   logic signed [COEF_WIDTH-1:0] tz2_ff;
   logic [2:0][TSH_W-1:0]     tsh2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_in[i] = C_W'(kx_ff[i]) + C_W'(ky_ff[i]) + (C_W'(kc_ff[i]) <<< PIX_FRAC);
      end
      for (int k = 0; k < 9; k++) begin
         rmag_in[k] = r1_ff[k][COEF_WIDTH-1] ? (~r1_ff[k] + 1'b1) : r1_ff[k];
      end
   end

   // stage 3: split products |R| * |c|
   logic [COEF_WIDTH+CLO_W-1:0] plo_ff [9];
   logic [COEF_WIDTH+CHI_W-1:0] phi_ff [9];
   logic [8:0]                  pneg3_ff;
   logic signed [COEF_WIDTH-1:0] tz3_ff;
   logic [2:0][TSH_W-1:0]       tsh3_ff;

   // stage 4: saturated magnitude of each product
   logic [RC_W-1:0]             prod_in [9];
   logic [SAT_W-1:0]            pmag4_ff [9];
   logic [8:0]                  pneg4_ff;
   logic signed [COEF_WIDTH-1:0] tz4_ff;
   logic [2:0][TSH_W-1:0]       tsh4_ff;

   // stage 5: signed, floor-shifted terms
   logic signed [TERM_W-1:0]    term_in [9], term_ff [9];
   logic signed [COEF_WIDTH-1:0] tz5_ff;
   logic [2:0][TSH_W-1:0]       tsh5_ff;

   // stage 6: ray direction w
   logic signed [W_W-1:0]       w_in [3], w_ff [3];
   logic signed [COEF_WIDTH-1:0] tz6_ff;
   logic [2:0][TSH_W-1:0]       tsh6_ff;

   // stage 7: miss test, divider operands
   ptgp_side_type               side7_in, side7_ff;
   logic [NUM_W-1:0]            num7_in, num7_ff;
   logic [WMAG_W-1:0]           dvs7_ff;

   always_comb begin
      logic signed [63:0]       sp;
      logic signed [63:0]       shv;
      logic [COEF_WIDTH-1:0]    tzmag;
      logic signed [W_W-1:0]    wabs;
      for (int k = 0; k < 9; k++) begin
         prod_in[k] = RC_W'(plo_ff[k]) + (RC_W'(phi_ff[k]) << CLO_W);
         sp         = pneg4_ff[k] ? -$signed({1'b0, pmag4_ff[k]})
                                  :  $signed({1'b0, pmag4_ff[k]});
         shv        = sp >>> W_SHIFT;
         term_in[k] = shv[TERM_W-1:0];
      end
      for (int i = 0; i < 3; i++) begin
         w_in[i] = W_W'(term_ff[3*i]) + W_W'(term_ff[3*i+1]) + W_W'(term_ff[3*i+2]);
      end
      // ray misses when w.z is zero or scale would be negative
      side7_in.invalid = (w_ff[2] == '0)
                         || ((tz6_ff > 0) && (w_ff[2] > 0))
                         || ((tz6_ff < 0) && (w_ff[2] < 0));
      for (int i = 0; i < 3; i++) begin
         wabs                = w_ff[i][W_W-1] ? -w_ff[i] : w_ff[i];
         side7_in.wneg[i]    = w_ff[i][W_W-1];
         side7_in.wmag[i]    = wabs[WMAG_W-1:0];
      end
      side7_in.tsh = tsh6_ff;
      tzmag        = tz6_ff[COEF_WIDTH-1] ? (~tz6_ff + 1'b1) : tz6_ff;
      num7_in      = {tzmag, {NUM_SHIFT{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v1_ff <= proj;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      // stage 1
      kx_ff   <= kx_in;
      ky_ff   <= ky_in;
      for (int i = 0; i < 3; i++) begin
         kc_ff[i] <= coef_ff[KINV_BASE+3*i+2];
      end
      for (int k = 0; k < 9; k++) begin
         r1_ff[k] <= coef_ff[ROT_BASE+k];
      end
      tz1_ff  <= coef_ff[TZ_SLOT];
      tsh1_ff <= tsh_in;
      // stage 2
      for (int i = 0; i < 3; i++) begin
         cmag_ff[i] <= c_in[i][C_W-1] ? CMAG_W'(-c_in[i]) : CMAG_W'(c_in[i]);
         cneg_ff[i] <= c_in[i][C_W-1];
      end
      rmag_ff <= rmag_in;
      for (int k = 0; k < 9; k++) begin
         rneg_ff[k] <= r1_ff[k][COEF_WIDTH-1];
      end
      tz2_ff  <= tz1_ff;
      tsh2_ff <= tsh1_ff;
      // stage 3: row i of R against column entry j of c
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            plo_ff[3*i+j]   <= rmag_ff[3*i+j] * cmag_ff[j][CLO_W-1:0];
            phi_ff[3*i+j]   <= rmag_ff[3*i+j] * cmag_ff[j][CMAG_W-1:CLO_W];
            pneg3_ff[3*i+j] <= rneg_ff[3*i+j] ^ cneg_ff[j];
         end
      end
      tz3_ff  <= tz2_ff;
      tsh3_ff <= tsh2_ff;
      // stage 4
      for (int k = 0; k < 9; k++) begin
         pmag4_ff[k] <= (|prod_in[k][RC_W-1:SAT_W]) ? {SAT_W{1'b1}}
                                                    : prod_in[k][SAT_W-1:0];
      end
      pneg4_ff <= pneg3_ff;
      tz4_ff   <= tz3_ff;
      tsh4_ff  <= tsh3_ff;
      // stage 5
      term_ff <= term_in;
      tz5_ff  <= tz4_ff;
      tsh5_ff <= tsh4_ff;
      // stage 6
      w_ff    <= w_in;
      tz6_ff  <= tz5_ff;
      tsh6_ff <= tsh5_ff;
      // stage 7
      side7_ff <= side7_in;
      num7_ff  <= num7_in;
      dvs7_ff  <= side7_in.wmag[2];
   end

   // scale = |num| / |w.z|
   logic               dv_valid;
   logic [NUM_W-1:0]   dv_quot;
   ptgp_side_type      dv_side;

   ptgp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_num    (num7_ff),
      .in_dvs    (dvs7_ff),
      .in_side   (side7_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // back end: scale*w, floor, translate, saturate
   logic m1_ff, m2_ff, m3_ff, m4_ff;
   logic [SLO_W+WLO_W-1:0]   ll_ff [3];
   logic [SLO_W+WHI_W-1:0]   lh_ff [3];
   logic [SHI_W+WLO_W-1:0]   hl_ff [3];
   logic [SHI_W+WHI_W-1:0]   hh_ff [3];
   ptgp_side_type            sd1_ff, sd2_ff, sd3_ff, sd4_ff;
   logic [PA_W-1:0]          pa_ff [3];
   logic [PB_W-1:0]          pb_ff [3];
   logic [PS_W-1:0]          ps_in [3];
   logic [SAT_W-1:0]         sm_ff [3];
   logic signed [FS_W-1:0]   fs_in [3], fs_ff [3];
   logic signed [POINT_WIDTH-1:0] pt_in [3];

   logic                          rsp_valid_ff;
   logic signed [POINT_WIDTH-1:0] rsp_point_x_ff, rsp_point_y_ff, rsp_point_z_ff;
   logic                          rsp_valid_res_ff;

   always_comb begin
      logic signed [63:0]    sp;
      logic signed [63:0]    shv;
      logic signed [SUM_W-1:0] sum;
      logic signed [63:0]    sum64;
      for (int i = 0; i < 3; i++) begin
         ps_in[i] = PS_W'(pa_ff[i]) + (PS_W'(pb_ff[i]) << SLO_W);
         sp       = sd3_ff.wneg[i] ? -$signed({1'b0, sm_ff[i]})
                                   :  $signed({1'b0, sm_ff[i]});
         shv      = sp >>> P_SHIFT;
         fs_in[i] = shv[FS_W-1:0];
         sum      = SUM_W'(fs_ff[i]) + SUM_W'($signed(sd4_ff.tsh[i]));
         sum64    = 64'(sum);
         if (sd4_ff.invalid) begin
            pt_in[i] = '0;
         end else if (sum64 > PT_MAX) begin
            pt_in[i] = PT_MAX[POINT_WIDTH-1:0];
         end else if (sum64 < PT_MIN) begin
            pt_in[i] = PT_MIN[POINT_WIDTH-1:0];
         end else begin
            pt_in[i] = sum64[POINT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff        <= 1'b0;
         m2_ff        <= 1'b0;
         m3_ff        <= 1'b0;
         m4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         m1_ff        <= dv_valid;
         m2_ff        <= m1_ff;
         m3_ff        <= m2_ff;
         m4_ff        <= m3_ff;
         rsp_valid_ff <= m4_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         // split 60 x 41 bit product into four partials
         ll_ff[i] <= dv_quot[SLO_W-1:0]     * dv_side.wmag[i][WLO_W-1:0];
         lh_ff[i] <= dv_quot[SLO_W-1:0]     * dv_side.wmag[i][WMAG_W-1:WLO_W];
         hl_ff[i] <= dv_quot[NUM_W-1:SLO_W] * dv_side.wmag[i][WLO_W-1:0];
         hh_ff[i] <= dv_quot[NUM_W-1:SLO_W] * dv_side.wmag[i][WMAG_W-1:WLO_W];
         pa_ff[i] <= PA_W'(ll_ff[i]) + (PA_W'(lh_ff[i]) << WLO_W);
         pb_ff[i] <= PB_W'(hl_ff[i]) + (PB_W'(hh_ff[i]) << WLO_W);
         sm_ff[i] <= (|ps_in[i][PS_W-1:SAT_W]) ? {SAT_W{1'b1}} : ps_in[i][SAT_W-1:0];
      end
      fs_ff  <= fs_in;
      sd1_ff <= dv_side;
      sd2_ff <= sd1_ff;
      sd3_ff <= sd2_ff;
      sd4_ff <= sd3_ff;
      rsp_point_x_ff   <= pt_in[0];
      rsp_point_y_ff   <= pt_in[1];
      rsp_point_z_ff   <= pt_in[2];
      rsp_valid_res_ff <= !sd4_ff.invalid;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_point_x   = rsp_point_x_ff;
   assign rsp_point_y   = rsp_point_y_ff;
   assign rsp_point_z   = rsp_point_z_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

`ifndef SYNTHESIS
   // a missed ray reports the zero point
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res)
         |-> ((rsp_point_x == '0) && (rsp_point_y == '0) && (rsp_point_z == '0)))
      else $error("invalid result with nonzero point");
   // a load lands in the store on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      load_wr |=> (coef_ff[$past(req_coef_index)] == $past(req_coef_value)))
      else $error("coefficient load lost");
   // zero w.z is always flagged before the divider
   assert property (@(posedge clock) disable iff (reset)
      (v6_ff && (w_ff[2] == '0)) |=> side7_ff.invalid)
      else $error("zero w.z not flagged");
   // a result never comes out of an empty back end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(m4_ff, 1))
      else $error("result strobe without item");
`endif

endmodule
